// File: rtl/lru_tag_cache_top_assert.svh
// Assertion macros for the tag cache checker.
`ifndef LRU_TAG_CACHE_TOP_ASSERT_SVH
`define LRU_TAG_CACHE_TOP_ASSERT_SVH

// Checked after reset is released.
`define LRU_TC_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked in every cycle, including while reset is asserted.
`define LRU_TC_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/lru_tc_pkg.sv
package lru_tc_pkg;

    localparam int ENTRIES  = 16;
    localparam int TAG_BITS = 64;

    localparam int MODE_W  = 2;
    localparam int KEY_W   = 64;
    localparam int LOC_W   = 8;
    localparam int STAMP_W = 32;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    typedef enum logic [MODE_W-1:0] {
        MODE_LOOKUP = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_REMOVE = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ACT,
        ST_SHIFT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic act;
        logic shift_init;
        logic shift;
        logic cnt_dec;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic walk_done;
        logic remove_hit;
        logic out_free;
    } dp_status_t;

endpackage

// File: rtl/lru_tc_if.sv
interface lru_tc_req_if import lru_tc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic [KEY_W-1:0]   key_tag;
    logic [LOC_W-1:0]   location;
    logic [STAMP_W-1:0] now;

    modport source (output valid, output mode, output key_tag, output location,
                    output now, input ready);
    modport sink   (input valid, input mode, input key_tag, input location,
                    input now, output ready);
endinterface

interface lru_tc_rsp_if import lru_tc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               hit;
    logic [LOC_W-1:0]   found_location;
    logic [CNT_W-1:0]   occupancy;

    modport source (output valid, output hit, output found_location,
                    output occupancy, input ready);
    modport sink   (input valid, input hit, input found_location,
                    input occupancy, output ready);
endinterface

// File: rtl/lru_tag_cache_top.sv
// Lookup and insert walk every held entry (SCAN), then ACT and FINISH give the result;
// a remove that hits adds a SHIFT walk over the entries above the match.
// Throughput: one item at a time; one memory read per cycle sets the walk length,
// and the next item is taken the cycle after the result is registered.
// Reset (async, active low) empties the cache and drops the result valid; entry
// storage is not cleared.
module lru_tag_cache_top import lru_tc_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    lru_tc_req_if.sink  req,
    lru_tc_rsp_if.source rsp
);

    dp_cmd_t    cmd;
    dp_status_t status;

    lru_tc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .cmd       (cmd),
        .status    (status)
    );

    lru_tc_dpath u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .mode           (req.mode),
        .key_tag        (req.key_tag),
        .location       (req.location),
        .now            (req.now),
        .rsp_ready      (rsp.ready),
        .rsp_valid      (rsp.valid),
        .hit            (rsp.hit),
        .found_location (rsp.found_location),
        .occupancy      (rsp.occupancy)
    );

endmodule

// File: rtl/lru_tc_ctrl.sv
module lru_tc_ctrl import lru_tc_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.walk_done)
                begin
                    state_next = ST_ACT;
                end
            end
            ST_ACT:
            begin
                cmd.act = 1'b1;
                if (status.remove_hit)
                begin
                    cmd.shift_init = 1'b1;
                    state_next     = ST_SHIFT;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (status.walk_done)
                begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/lru_tc_dpath.sv
module lru_tc_dpath import lru_tc_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            cmd,
    output dp_status_t         status,
    input  logic [MODE_W-1:0]  mode,
    input  logic [KEY_W-1:0]   key_tag,
    input  logic [LOC_W-1:0]   location,
    input  logic [STAMP_W-1:0] now,
    input  logic               rsp_ready,
    output logic               rsp_valid,
    output logic               hit,
    output logic [LOC_W-1:0]   found_location,
    output logic [CNT_W-1:0]   occupancy
);

    // entry storage; valid entries always sit at 0 .. count-1
    logic [TAG_BITS-1:0] tag_mem   [ENTRIES];
    logic [LOC_W-1:0]    loc_mem   [ENTRIES];
    logic [STAMP_W-1:0]  stamp_mem [ENTRIES];

    // operation being worked on
    logic [MODE_W-1:0]   mode_reg;
    logic [TAG_BITS-1:0] tag_reg;
    logic [LOC_W-1:0]    loc_reg;
    logic [STAMP_W-1:0]  now_reg;

    // walk state
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    ptr_reg, ptr_next;
    logic                pend_reg, pend_next;
    logic [IDX_W-1:0]    pidx_reg;
    logic [TAG_BITS-1:0] rd_tag_reg;
    logic [LOC_W-1:0]    rd_loc_reg;
    logic [STAMP_W-1:0]  rd_stamp_reg;

    // search results
    logic                found_reg, found_next;
    logic [IDX_W-1:0]    match_idx_reg, match_idx_next;
    logic [LOC_W-1:0]    found_loc_reg, found_loc_next;
    logic [IDX_W-1:0]    min_idx_reg, min_idx_next;
    logic [STAMP_W-1:0]  min_stamp_reg, min_stamp_next;

    // result register
    logic                out_valid_reg, out_valid_next;
    logic                hit_reg;
    logic [LOC_W-1:0]    out_loc_reg;
    logic [CNT_W-1:0]    occ_reg;

    // memory write port
    logic                tag_we, loc_we, stamp_we;
    logic [IDX_W-1:0]    wr_addr;
    logic [TAG_BITS-1:0] wr_tag;
    logic [LOC_W-1:0]    wr_loc;
    logic [STAMP_W-1:0]  wr_stamp;

    logic                rd_go;
    logic [IDX_W-1:0]    rd_addr;
    logic                not_full;
    logic                mode_ok;

    assign rd_addr  = ptr_reg[IDX_W-1:0];
    assign rd_go    = (cmd.scan || cmd.shift) && (ptr_reg < count_reg);
    assign not_full = count_reg < CNT_W'(ENTRIES);
    assign mode_ok  = (mode_reg == MODE_LOOKUP) || (mode_reg == MODE_INSERT)
                      || (mode_reg == MODE_REMOVE);

    assign status.walk_done  = (ptr_reg >= count_reg) && !pend_reg;
    assign status.remove_hit = (mode_reg == MODE_REMOVE) && found_reg;
    assign status.out_free   = !out_valid_reg || rsp_ready;

    always_comb
    begin
        ptr_next       = ptr_reg;
        pend_next      = pend_reg;
        found_next     = found_reg;
        match_idx_next = match_idx_reg;
        found_loc_next = found_loc_reg;
        min_idx_next   = min_idx_reg;
        min_stamp_next = min_stamp_reg;
        count_next     = count_reg;
        tag_we         = 1'b0;
        loc_we         = 1'b0;
        stamp_we       = 1'b0;
        wr_addr        = match_idx_reg;
        wr_tag         = tag_reg;
        wr_loc         = loc_reg;
        wr_stamp       = now_reg;

        if (cmd.load)
        begin
            ptr_next   = '0;
            pend_next  = 1'b0;
            found_next = 1'b0;
        end
        else if (cmd.shift_init)
        begin
            ptr_next  = CNT_W'(match_idx_reg) + CNT_W'(1);
            pend_next = 1'b0;
        end
        else if (cmd.scan || cmd.shift)
        begin
            pend_next = rd_go;
            if (rd_go)
            begin
                ptr_next = ptr_reg + CNT_W'(1);
            end
        end

        // compare the entry read in the previous cycle; ascending walk keeps
        // the lowest index on equal tags and on equal stamps
        if (cmd.scan && pend_reg)
        begin
            if ((rd_tag_reg == tag_reg) && !found_reg)
            begin
                found_next     = 1'b1;
                match_idx_next = pidx_reg;
                found_loc_next = rd_loc_reg;
            end
            if ((pidx_reg == '0) || (rd_stamp_reg < min_stamp_reg))
            begin
                min_idx_next   = pidx_reg;
                min_stamp_next = rd_stamp_reg;
            end
        end

        // remove: entry read from j+1 is written back at j
        if (cmd.shift && pend_reg)
        begin
            tag_we   = 1'b1;
            loc_we   = 1'b1;
            stamp_we = 1'b1;
            wr_addr  = pidx_reg - IDX_W'(1);
            wr_tag   = rd_tag_reg;
            wr_loc   = rd_loc_reg;
            wr_stamp = rd_stamp_reg;
        end

        if (cmd.act)
        begin
            if ((mode_reg == MODE_LOOKUP) && found_reg)
            begin
                stamp_we = 1'b1;
            end
            else if (mode_reg == MODE_INSERT)
            begin
                loc_we   = 1'b1;
                stamp_we = 1'b1;
                if (!found_reg)
                begin
                    tag_we = 1'b1;
                    if (not_full)
                    begin
                        wr_addr    = count_reg[IDX_W-1:0];
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        wr_addr = min_idx_reg;
                    end
                end
            end
        end

        if (cmd.cnt_dec)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ptr_reg       <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= mode;
            tag_reg  <= key_tag[TAG_BITS-1:0];
            loc_reg  <= location;
            now_reg  <= now;
        end
        if (rd_go)
        begin
            pidx_reg <= rd_addr;
        end
        match_idx_reg <= match_idx_next;
        found_loc_reg <= found_loc_next;
        min_idx_reg   <= min_idx_next;
        min_stamp_reg <= min_stamp_next;
        if (cmd.finish)
        begin
            hit_reg     <= found_reg && mode_ok;
            out_loc_reg <= ((mode_reg == MODE_LOOKUP) && found_reg) ? found_loc_reg : '0;
            occ_reg     <= count_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tag_mem[wr_addr] <= wr_tag;
        end
        if (loc_we)
        begin
            loc_mem[wr_addr] <= wr_loc;
        end
        if (stamp_we)
        begin
            stamp_mem[wr_addr] <= wr_stamp;
        end
        if (rd_go)
        begin
            rd_tag_reg   <= tag_mem[rd_addr];
            rd_loc_reg   <= loc_mem[rd_addr];
            rd_stamp_reg <= stamp_mem[rd_addr];
        end
    end

    assign rsp_valid      = out_valid_reg;
    assign hit            = hit_reg;
    assign found_location = out_loc_reg;
    assign occupancy      = occ_reg;

endmodule

// File: rtl/lru_tc_checker.sv
module lru_tc_checker import lru_tc_pkg::*; (
    input logic             clk,
    input logic             rst_n,
    input logic             req_valid,
    input logic             req_ready,
    input logic             rsp_valid,
    input logic             rsp_ready,
    input logic             rsp_hit,
    input logic [LOC_W-1:0] rsp_found_location,
    input logic [CNT_W-1:0] rsp_occupancy
);

`include "lru_tag_cache_top_assert.svh"

    // one item in flight: no transfer right after a transfer
    `LRU_TC_ASSERT(a_one_in_flight, (req_valid && req_ready) |=> !req_ready, "input taken while busy")
    `LRU_TC_ASSERT(a_occ_bound, rsp_valid |-> (rsp_occupancy <= CNT_W'(ENTRIES)), "occupancy too large")
    `LRU_TC_ASSERT(a_loc_needs_hit, (rsp_valid && !rsp_hit) |-> (rsp_found_location == '0), "location without hit")
    `LRU_TC_ASSERT(a_rsp_hold, (rsp_valid && !rsp_ready) |=> rsp_valid, "result dropped before transfer")
    // reset held over a full cycle: valid has settled low
    `LRU_TC_ASSERT_ALWAYS(a_rst_quiet, (!rst_n && $past(!rst_n)) |-> !rsp_valid, "result valid during reset")

endmodule

bind lru_tag_cache_top lru_tc_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .req_valid          (req.valid),
    .req_ready          (req.ready),
    .rsp_valid          (rsp.valid),
    .rsp_ready          (rsp.ready),
    .rsp_hit            (rsp.hit),
    .rsp_found_location (rsp.found_location),
    .rsp_occupancy      (rsp.occupancy)
);

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import lru_tc_pkg::*;

    localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;
    localparam logic [KEY_W-1:0]  TAG_MASK = {KEY_W{1'b1}} >> (KEY_W - TAG_BITS);
    localparam int RANDOM_OPS  = 1725;
    localparam int TAG_POOL    = 24;
    localparam int DRAIN_WAIT  = 2 * ENTRIES + 8;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [KEY_W-1:0]   key_tag;
        logic [LOC_W-1:0]   location;
        logic [STAMP_W-1:0] now;
    } cache_op_t;

    typedef struct packed {
        logic               hit;
        logic [LOC_W-1:0]   found_location;
        logic [CNT_W-1:0]   occupancy;
    } cache_rsp_t;

    logic clk = 1'b0;
    logic rst_n;

    lru_tc_req_if req_if ();
    lru_tc_rsp_if rsp_if ();

    lru_tag_cache_top i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    cache_op_t  op_pending[$];
    cache_rsp_t rsp_expected[$];
    int         mismatches = 0;
    int         ops_sent = 0;
    int         cycle_count = 0;

    // shadow copy of the cache
    logic [KEY_W-1:0]   cache_tag   [ENTRIES];
    logic [LOC_W-1:0]   cache_loc   [ENTRIES];
    logic [STAMP_W-1:0] cache_stamp [ENTRIES];
    int                 cache_count = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.mode = '0;
        req_if.key_tag = '0;
        req_if.location = '0;
        req_if.now = '0;
        rsp_if.ready = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // most gaps short, a few long
    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 80)
            return $urandom_range(1, 3);
        else if (pick < 95)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic cache_rsp_t cache_predict(cache_op_t op);
        cache_rsp_t       r;
        logic [KEY_W-1:0] tag;
        int               slot;
        int               j;
        r = '0;
        tag = op.key_tag & TAG_MASK;
        slot = -1;
        for (j = 0; j < cache_count; j++)
        begin
            if (slot < 0 && cache_tag[j] == tag)
                slot = j;
        end
        case (op.mode)
            MODE_LOOKUP:
            begin
                if (slot >= 0)
                begin
                    cache_stamp[slot] = op.now;
                    r.found_location = cache_loc[slot];
                    r.hit = 1'b1;
                end
            end
            MODE_INSERT:
            begin
                if (slot >= 0)
                    r.hit = 1'b1;
                else if (cache_count < ENTRIES)
                begin
                    slot = cache_count;
                    cache_count++;
                end
                else
                begin
                    // full: evict the oldest stamp, lowest index on a tie
                    slot = 0;
                    for (j = 1; j < ENTRIES; j++)
                    begin
                        if (cache_stamp[j] < cache_stamp[slot])
                            slot = j;
                    end
                end
                cache_tag[slot] = tag;
                cache_loc[slot] = op.location;
                cache_stamp[slot] = op.now;
            end
            MODE_REMOVE:
            begin
                if (slot >= 0)
                begin
                    for (j = slot; j + 1 < cache_count; j++)
                    begin
                        cache_tag[j] = cache_tag[j + 1];
                        cache_loc[j] = cache_loc[j + 1];
                        cache_stamp[j] = cache_stamp[j + 1];
                    end
                    cache_count--;
                    r.hit = 1'b1;
                end
            end
            default: ;
        endcase
        r.occupancy = cache_count[CNT_W-1:0];
        return r;
    endfunction

    task automatic queue_op(input logic [MODE_W-1:0] m, input logic [KEY_W-1:0] tag,
                            input logic [LOC_W-1:0] loc, input logic [STAMP_W-1:0] stamp);
        op_pending.push_back(cache_op_t'{mode: m, key_tag: tag, location: loc, now: stamp});
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin : drive_req
        cache_op_t nxt;
        logic      offer;
        int        send_gap;
        if (!rst_n)
        begin
            req_if.valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            offer = req_if.valid;
            if (req_if.valid && req_if.ready)
            begin
                rsp_expected.push_back(cache_predict(cache_op_t'{
                    mode: req_if.mode, key_tag: req_if.key_tag,
                    location: req_if.location, now: req_if.now}));
                ops_sent++;
                offer = 1'b0;
            end
            if (!offer)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (op_pending.size() > 0)
                begin
                    nxt = op_pending.pop_front();
                    req_if.mode <= nxt.mode;
                    req_if.key_tag <= nxt.key_tag;
                    req_if.location <= nxt.location;
                    req_if.now <= nxt.now;
                    offer = 1'b1;
                    if (((ops_sent / 150) % 5) != 4 && $urandom_range(0, 99) < 30)
                        send_gap = idle_len();
                end
            end
            req_if.valid <= offer;
        end
    end

    // result ready: random stalls plus a long hold-off now and then
    always @(posedge clk or negedge rst_n)
    begin : drive_ready
        int   taken;
        int   stall_left;
        int   hold_left;
        int   hold_mark;
        logic rdy;
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            taken = 0;
            stall_left = 0;
            hold_left = 0;
            hold_mark = 60;
        end
        else
        begin
            if (rsp_if.valid && rsp_if.ready)
                taken++;
            rdy = 1'b0;
            if (hold_left > 0)
                hold_left--;
            else if (taken >= hold_mark)
            begin
                hold_left = HOLD_CYCLES;
                hold_mark += 900;
            end
            else if (stall_left > 0)
                stall_left--;
            else
            begin
                rdy = 1'b1;
                if (((taken / 150) % 5) != 4 && $urandom_range(0, 99) < 30)
                    stall_left = idle_len();
            end
            rsp_if.ready <= rdy;
        end
    end

    always @(posedge clk)
    begin : check_rsp
        cache_rsp_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (rsp_expected.size() == 0)
            begin
                $error("result transfer with nothing expected");
                mismatches++;
            end
            else
            begin
                want = rsp_expected.pop_front();
                if (rsp_if.hit !== want.hit)
                begin
                    $error("hit: expected %0d, got %0d", want.hit, rsp_if.hit);
                    mismatches++;
                end
                if (rsp_if.found_location !== want.found_location)
                begin
                    $error("found_location: expected %0d, got %0d",
                           want.found_location, rsp_if.found_location);
                    mismatches++;
                end
                if (rsp_if.occupancy !== want.occupancy)
                begin
                    $error("occupancy: expected %0d, got %0d",
                           want.occupancy, rsp_if.occupancy);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : stimulus
        logic [KEY_W-1:0]   tag_pool [TAG_POOL];
        logic [KEY_W-1:0]   tag;
        logic [MODE_W-1:0]  m;
        logic [STAMP_W-1:0] stamp_clock;
        logic [STAMP_W-1:0] stamp;
        logic               fill_phase;
        int                 pick;
        int                 n;

        // empty cache: misses and the unused code
        queue_op(MODE_LOOKUP, 64'h1234, 8'd7, 32'd1);
        queue_op(MODE_REMOVE, 64'h1234, 8'd9, 32'd2);
        queue_op(MODE_NOP, {KEY_W{1'b1}}, {LOC_W{1'b1}}, {STAMP_W{1'b1}});
        // field extremes
        queue_op(MODE_INSERT, '0, '0, '0);
        queue_op(MODE_INSERT, {KEY_W{1'b1}}, {LOC_W{1'b1}}, {STAMP_W{1'b1}});
        queue_op(MODE_LOOKUP, {KEY_W{1'b1}}, '0, {STAMP_W{1'b1}});
        // update in place, then fill with equal stamps so eviction hits a tie
        queue_op(MODE_INSERT, '0, 8'hA5, 32'd3);
        queue_op(MODE_LOOKUP, '0, 8'h11, 32'd3);
        for (n = 0; n < ENTRIES - 2; n++)
            queue_op(MODE_INSERT, 64'h100 + n, n[LOC_W-1:0], 32'd3);
        queue_op(MODE_INSERT, 64'hDEAD, 8'h5A, 32'd9);
        queue_op(MODE_LOOKUP, '0, '0, 32'd10);
        // remove from the middle, then the same tag again (miss)
        queue_op(MODE_REMOVE, 64'h105, 8'h33, 32'd11);
        queue_op(MODE_REMOVE, 64'h105, 8'h33, 32'd12);
        queue_op(MODE_NOP, {$urandom, $urandom}, 8'h3C, $urandom);

        tag_pool[0] = '0;
        tag_pool[1] = {KEY_W{1'b1}};
        for (n = 2; n < TAG_POOL; n++)
            tag_pool[n] = {$urandom, $urandom};
        stamp_clock = 32'd100;

        // alternate fill-heavy and drain-heavy stretches
        for (n = 0; n < RANDOM_OPS; n++)
        begin
            fill_phase = ((n / 120) % 2) == 0;
            pick = $urandom_range(0, 99);
            if (pick < 5)
                m = MODE_NOP;
            else if (fill_phase)
                m = (pick < 45) ? MODE_LOOKUP : (pick < 85) ? MODE_INSERT : MODE_REMOVE;
            else
                m = (pick < 40) ? MODE_LOOKUP : (pick < 55) ? MODE_INSERT : MODE_REMOVE;

            if ($urandom_range(0, 99) < 2)
                tag_pool[$urandom_range(0, TAG_POOL - 1)] = {$urandom, $urandom};
            if ($urandom_range(0, 99) < 85)
                tag = tag_pool[$urandom_range(0, TAG_POOL - 1)];
            else
                tag = {$urandom, $urandom};

            // mostly a slow clock with ties, sometimes any value
            if ($urandom_range(0, 99) < 90)
            begin
                stamp_clock += $urandom_range(0, 2);
                stamp = stamp_clock;
            end
            else
                stamp = $urandom;

            queue_op(m, tag, LOC_W'($urandom_range(0, 255)), stamp);
        end

        wait (rst_n === 1'b1);
        @(negedge clk);
        while (op_pending.size() != 0 || req_if.valid)
            @(negedge clk);
        while (rsp_expected.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);

        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
